/* src/bsh_pkg.sv */
// bsh_pkg: shared types, constants and helper functions of the bash sponge hash.
// No dependencies; imported by bsh_round, bsh_datapath, bsh_ctrl and the top level.
`default_nettype none

package bsh_pkg;

   localparam int STATE_WORDS = 24;
   localparam int COLS        = 8;
   localparam int ROUNDS      = 24;

   localparam logic [63:0] LFSR_SEED = 64'h3BF5080AC8BA94B1;
   localparam logic [63:0] LFSR_POLY = 64'hDC2BE1997FE0D8AE;
   localparam logic [7:0]  PAD_BYTE  = 8'h40;
   localparam logic [3:0]  RESET_K   = 4'd4;
   localparam logic [3:0]  MIN_K     = 4'd1;
   localparam logic [3:0]  MAX_K     = 4'd8;
   localparam logic [7:0]  FULL_BYTES = 8'd192;

   localparam logic [4:0] PERM_SRC [STATE_WORDS] = '{
      5'd15, 5'd10, 5'd9,  5'd12, 5'd11, 5'd14, 5'd13, 5'd8,
      5'd17, 5'd16, 5'd19, 5'd18, 5'd21, 5'd20, 5'd23, 5'd22,
      5'd6,  5'd3,  5'd0,  5'd5,  5'd2,  5'd7,  5'd4,  5'd1
   };

   // per-column rotation amounts (each sequence steps by x7 mod 64)
   localparam logic [5:0] ROT_M1 [COLS] = '{6'd8,  6'd56, 6'd8,  6'd56,
                                            6'd8,  6'd56, 6'd8,  6'd56};
   localparam logic [5:0] ROT_N1 [COLS] = '{6'd53, 6'd51, 6'd37, 6'd3,
                                            6'd21, 6'd19, 6'd5,  6'd35};
   localparam logic [5:0] ROT_M2 [COLS] = '{6'd14, 6'd34, 6'd46, 6'd2,
                                            6'd14, 6'd34, 6'd46, 6'd2};
   localparam logic [5:0] ROT_N2 [COLS] = '{6'd1,  6'd7,  6'd49, 6'd23,
                                            6'd33, 6'd39, 6'd17, 6'd55};

   typedef logic [STATE_WORDS-1:0][63:0] state_type;

   typedef struct packed {
      logic       absorb;
      logic       pad;
      logic       round;
      logic       emit;
      logic       init;
      logic [2:0] emit_idx;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic       block_full;
      logic       out_free;
      logic [3:0] level_k;
   } status_type;

   function automatic logic [63:0] rotl(input logic [63:0] w, input logic [5:0] n);
      logic [127:0] dbl;
      dbl = {w, w} << n;
      return dbl[127:64];
   endfunction

   function automatic logic [63:0] lfsr_step(input logic [63:0] c);
      return c[0] ? ((c >> 1) ^ LFSR_POLY) : (c >> 1);
   endfunction

   function automatic logic [3:0] clamp_k(input logic [3:0] v);
      if (v < MIN_K) return MIN_K;
      if (v > MAX_K) return MAX_K;
      return v;
   endfunction

   function automatic state_type init_state(input logic [3:0] k);
      state_type s;
      s = '0;
      s[STATE_WORDS-1] = {57'd0, k, 3'd0};
      return s;
   endfunction

endpackage

`default_nettype wire

/* src/bsh_chan_if.sv */
// bsh_chan_if: valid/ready channel interfaces for requests and digest responses.
// Depends on nothing; used by the top level and the datapath.
`default_nettype none

interface bsh_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;
   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface bsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic        digest_last;
   modport source (output valid, output digest_word, output digest_last, input ready);
   modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

`default_nettype wire

/* src/bsh_round.sv */
// bsh_round: one round of the bash-f permutation (8 column S-boxes, word shuffle, constant).
// Depends on bsh_pkg.
`default_nettype none

module bsh_round
   import bsh_pkg::*;
(
   input  state_type   st_in,
   input  logic [63:0] rc,
   output state_type   st_out
);

   always_comb begin
      state_type   mid;
      logic [63:0] a, b, d, t0, t1, t2;
      mid = st_in;
      for (int j = 0; j < COLS; j++) begin
         a  = st_in[j];
         b  = st_in[COLS + j];
         d  = st_in[2*COLS + j];
         t0 = rotl(a, ROT_M1[j]);
         a  = a ^ b ^ d;
         t1 = b ^ rotl(a, ROT_N1[j]);
         b  = t0 ^ t1;
         d  = d ^ rotl(d, ROT_M2[j]) ^ rotl(t1, ROT_N2[j]);
         t0 = ~d | b;
         t1 = a | d;
         t2 = a & b;
         mid[j]          = a ^ t0;
         mid[COLS + j]   = b ^ t1;
         mid[2*COLS + j] = d ^ t2;
      end
      for (int i = 0; i < STATE_WORDS; i++) begin
         st_out[i] = mid[PERM_SRC[i]];
      end
      st_out[STATE_WORDS-1] = mid[PERM_SRC[STATE_WORDS-1]] ^ rc;
   end

endmodule

`default_nettype wire

/* src/bsh_datapath.sv */
// bsh_datapath: sponge state, byte count, level register, round constant LFSR,
// absorb/pad write logic and the digest output register. Depends on bsh_pkg,
// bsh_chan_if and bsh_round.
`default_nettype none

module bsh_datapath
   import bsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic [7:0] req_byte,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   bsh_rsp_if.source  rsp_chan
);

   state_type   st_ff, st_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [3:0]  level_ff, level_in;
   logic [63:0] lfsr_ff, lfsr_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_word_ff, out_word_in;
   logic        out_last_ff, out_last_in;

   logic [7:0]  rate;
   logic [7:0]  pos;
   logic [7:0]  pos_next;
   state_type   absorb_st, pad_st, round_st;

   assign rate     = FULL_BYTES - {level_ff, 4'd0};
   assign pos      = (cnt_ff >= rate) ? 8'd0 : cnt_ff;
   assign pos_next = pos + 8'd1;

   assign status.block_full = (pos_next >= rate);
   assign status.out_free   = !out_valid_ff || rsp_chan.ready;
   assign status.level_k    = level_ff;

   bsh_round u_round (
      .st_in  (st_ff),
      .rc     (lfsr_ff),
      .st_out (round_st)
   );

   always_comb begin
      logic [7:0] bi;
      absorb_st = st_ff;
      pad_st    = st_ff;
      for (int w = 0; w < STATE_WORDS; w++) begin
         for (int l = 0; l < 8; l++) begin
            bi = 8'(w * 8 + l);
            if (bi == pos) begin
               absorb_st[w][8*l +: 8] = req_byte;
               pad_st[w][8*l +: 8]    = PAD_BYTE;
            end else if (bi > pos && bi < rate) begin
               pad_st[w][8*l +: 8] = 8'd0;
            end
         end
      end
   end

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      level_in = level_ff;
      lfsr_in  = cmd.round ? lfsr_step(lfsr_ff) : LFSR_SEED;
      if (csr_wr_en) begin
         level_in = clamp_k(csr_wr_data);
         st_in    = init_state(clamp_k(csr_wr_data));
         cnt_in   = 8'd0;
      end else if (cmd.init) begin
         st_in  = init_state(level_ff);
         cnt_in = 8'd0;
      end else if (cmd.round) begin
         st_in = round_st;
      end else if (cmd.absorb) begin
         st_in  = absorb_st;
         cnt_in = status.block_full ? 8'd0 : pos_next;
      end else if (cmd.pad) begin
         st_in  = pad_st;
         cnt_in = 8'd0;
      end
   end

   always_comb begin
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (cmd.emit) begin
         out_word_in  = st_ff[{2'b00, cmd.emit_idx}];
         out_last_in  = cmd.emit_last;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= init_state(RESET_K);
         cnt_ff       <= 8'd0;
         level_ff     <= RESET_K;
         lfsr_ff      <= LFSR_SEED;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         lfsr_ff      <= lfsr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.digest_word = out_word_ff;
   assign rsp_chan.digest_last = out_last_ff;

endmodule

`default_nettype wire

/* src/bsh_ctrl.sv */
// bsh_ctrl: controller for absorb, permutation rounds and digest emission.
// Depends on bsh_pkg.
`default_nettype none

module bsh_ctrl
   import bsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PERM = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic ACT_ABSORB = 1'b0;

   logic [1:0] state_ff, state_in;
   logic [4:0] rnd_ff, rnd_in;
   logic [2:0] idx_ff, idx_in;
   logic       fin_ff, fin_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      rnd_in        = rnd_ff;
      idx_in        = idx_ff;
      fin_in        = fin_ff;
      cmd           = '0;
      cmd.emit_idx  = idx_ff;
      cmd.emit_last = ({1'b0, idx_ff} == (status.level_k - 4'd1));
      case (state_ff)
         ST_IDLE: begin
            rnd_in = 5'd0;
            idx_in = 3'd0;
            if (req_valid) begin
               if (req_action == ACT_ABSORB) begin
                  cmd.absorb = 1'b1;
                  fin_in     = 1'b0;
                  if (status.block_full) state_in = ST_PERM;
               end else begin
                  cmd.pad  = 1'b1;
                  fin_in   = 1'b1;
                  state_in = ST_PERM;
               end
            end
         end
         ST_PERM: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 5'd1;
            if (rnd_ff == 5'(ROUNDS - 1)) begin
               state_in = fin_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (cmd.emit_last) begin
                  cmd.init = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= 5'd0;
         idx_ff   <= 3'd0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

`default_nettype wire

/* src/bash_sponge_hash_top.sv */
// bash_sponge_hash_top: bash hash over a byte stream, one absorb byte per cycle while idle.
// Absorb: the byte that fills the rate block also starts the permutation rounds.
// Finish: pad, rounds (one round per cycle), then k digest words, one a cycle when out_free.
// Throughput: 1 byte/cycle; input stalls for the rounds after each 192-16k byte rate block.
// Reset (synchronous): k = 4, word 23 = 32, other words 0, LFSR = seed, no response pending.
// Depends on bsh_pkg, bsh_chan_if, bsh_ctrl, bsh_datapath, bsh_round.
`default_nettype none

module bash_sponge_hash_top
   import bsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bsh_req_if.sink    req_chan,
   bsh_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_chan.ready = req_ready;

   bsh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   bsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_byte    (req_chan.data_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_chan    (rsp_chan)
   );

   a_no_accept_in_round: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !req_ready)
      else $error("request accepted during permutation");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.absorb, cmd.pad, cmd.round, cmd.emit}))
      else $error("conflicting datapath commands");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.init) |=> (rsp_chan.valid && rsp_chan.digest_last && req_ready))
      else $error("final digest word not presented");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("digest word overwritten before transfer");

endmodule

`default_nettype wire
